[rtl/core/rbo_pkg.sv]
`timescale 1ns / 1ps
// Package for the rotation basis orthonormalizer: widths, payload types, sideband struct.
// No dependencies; used by rbo_norm, rbo_cross and the top level.
package rbo_pkg;

    // Component format: signed Q2.(COMPONENT_WIDTH-2)
    localparam int COMPONENT_WIDTH = 16;
    localparam int FRAC_BITS       = COMPONENT_WIDTH - 2;

    // Vector fed to a normalizer: wide enough for an exact cross product
    // of two unit vectors (each component at most 2^FRAC_BITS in magnitude).
    localparam int VEC_W  = 2 * FRAC_BITS + 3;
    // Magnitudes never reach 2^(VEC_W-1): inputs and cross products stay below.
    localparam int MAG_W  = VEC_W - 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int ROOT_W = SUM_W / 2;
    // Dividend of the rounding divide and quotient width (quotient <= 2^FRAC_BITS)
    localparam int NUM_W  = MAG_W + FRAC_BITS + 1;
    localparam int Q_W    = FRAC_BITS + 1;

    typedef logic [COMPONENT_WIDTH-1:0] comp_t;
    typedef comp_t [2:0]                vec3_t;
    typedef logic [2:0][VEC_W-1:0]      wvec_t;

    // Data that rides along a normalizer: two finished axes and the flag so far
    typedef struct packed {
        vec3_t va;
        vec3_t vb;
        logic  deg;
    } side_t;

    // One finished result
    typedef struct packed {
        vec3_t x;
        vec3_t y;
        vec3_t z;
        logic  deg;
    } res_t;

endpackage

[rtl/core/rbo_norm.sv]
`timescale 1ns / 1ps
// Pipelined vector normalizer: abs, squares, sum, bit-serial square root,
// restoring rounding divide in three lanes, sign restore. Uses rbo_pkg.
module rbo_norm (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  rbo_pkg::wvec_t in_vec,
    input  rbo_pkg::side_t in_side,
    output logic           out_valid,
    output rbo_pkg::vec3_t out_vec,
    output logic           out_zero,
    output rbo_pkg::side_t out_side
);

    localparam int VEC_W  = rbo_pkg::VEC_W;
    localparam int MAG_W  = rbo_pkg::MAG_W;
    localparam int SQ_W   = rbo_pkg::SQ_W;
    localparam int SUM_W  = rbo_pkg::SUM_W;
    localparam int ROOT_W = rbo_pkg::ROOT_W;
    localparam int NUM_W  = rbo_pkg::NUM_W;
    localparam int Q_W    = rbo_pkg::Q_W;
    localparam int FRAC   = rbo_pkg::FRAC_BITS;
    localparam int CW     = rbo_pkg::COMPONENT_WIDTH;

    // ---------------- stage A: magnitudes and signs
    logic                       a_valid_reg;
    logic [2:0][MAG_W-1:0]      a_mag_reg, a_mag_next;
    logic [2:0]                 a_neg_reg, a_neg_next;
    rbo_pkg::side_t             a_side_reg;

    always_comb begin
        logic [VEC_W-1:0] absv;
        for (int i = 0; i < 3; i++) begin
            a_neg_next[i] = in_vec[i][VEC_W-1];
            absv          = a_neg_next[i] ? (~in_vec[i] + 1'b1) : in_vec[i];
            a_mag_next[i] = absv[MAG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_mag_reg  <= a_mag_next;
            a_neg_reg  <= a_neg_next;
            a_side_reg <= in_side;
        end
    end

    // ---------------- stage B: squares
    logic                       b_valid_reg;
    logic [2:0][SQ_W-1:0]       b_sq_reg, b_sq_next;
    logic [2:0][MAG_W-1:0]      b_mag_reg;
    logic [2:0]                 b_neg_reg;
    rbo_pkg::side_t             b_side_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            b_sq_next[i] = SQ_W'(a_mag_reg[i]) * SQ_W'(a_mag_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_sq_reg   <= b_sq_next;
            b_mag_reg  <= a_mag_reg;
            b_neg_reg  <= a_neg_reg;
            b_side_reg <= a_side_reg;
        end
    end

    // ---------------- square root: index 0 holds the sum, one root bit per stage
    logic                       sq_valid_reg [0:ROOT_W];
    logic [SUM_W-1:0]           sq_rem_reg   [0:ROOT_W];
    logic [SUM_W-1:0]           sq_root_reg  [0:ROOT_W];
    logic [2:0][MAG_W-1:0]      sq_mag_reg   [0:ROOT_W];
    logic [2:0]                 sq_neg_reg   [0:ROOT_W];
    rbo_pkg::side_t             sq_side_reg  [0:ROOT_W];
    logic [SUM_W-1:0]           sq_rem_next  [0:ROOT_W-1];
    logic [SUM_W-1:0]           sq_root_next [0:ROOT_W-1];
    logic [SUM_W-1:0]           sum_next;

    assign sum_next = SUM_W'(b_sq_reg[0]) + SUM_W'(b_sq_reg[1]) + SUM_W'(b_sq_reg[2]);

    always_comb begin
        logic [SUM_W:0] bitv;
        logic [SUM_W:0] trial;
        logic           take;
        for (int i = 0; i < ROOT_W; i++) begin
            bitv  = (SUM_W+1)'(1) << (2 * (ROOT_W - 1 - i));
            trial = {1'b0, sq_root_reg[i]} + bitv;
            take  = ({1'b0, sq_rem_reg[i]} >= trial);
            sq_rem_next[i]  = take ? (sq_rem_reg[i] - trial[SUM_W-1:0]) : sq_rem_reg[i];
            sq_root_next[i] = take ? ((sq_root_reg[i] >> 1) + bitv[SUM_W-1:0])
                                   : (sq_root_reg[i] >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= ROOT_W; i++) begin
                sq_valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            sq_valid_reg[0] <= b_valid_reg;
            for (int i = 0; i < ROOT_W; i++) begin
                sq_valid_reg[i+1] <= sq_valid_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_rem_reg[0]  <= sum_next;
            sq_root_reg[0] <= '0;
            sq_mag_reg[0]  <= b_mag_reg;
            sq_neg_reg[0]  <= b_neg_reg;
            sq_side_reg[0] <= b_side_reg;
            for (int i = 0; i < ROOT_W; i++) begin
                sq_rem_reg[i+1]  <= sq_rem_next[i];
                sq_root_reg[i+1] <= sq_root_next[i];
                sq_mag_reg[i+1]  <= sq_mag_reg[i];
                sq_neg_reg[i+1]  <= sq_neg_reg[i];
                sq_side_reg[i+1] <= sq_side_reg[i];
            end
        end
    end

    // ---------------- divide: index 0 holds mag*2^FRAC + n/2, one quotient bit per stage
    logic                       dv_valid_reg [0:Q_W];
    logic [2:0][NUM_W-1:0]      dv_rem_reg   [0:Q_W];
    logic [2:0][Q_W-1:0]        dv_q_reg     [0:Q_W];
    logic [ROOT_W-1:0]          dv_den_reg   [0:Q_W];
    logic [2:0]                 dv_neg_reg   [0:Q_W];
    logic                       dv_zero_reg  [0:Q_W];
    rbo_pkg::side_t             dv_side_reg  [0:Q_W];
    logic [2:0][NUM_W-1:0]      dv_rem_next  [0:Q_W-1];
    logic [2:0][Q_W-1:0]        dv_q_next    [0:Q_W-1];
    logic [2:0][NUM_W-1:0]      num_next;
    logic [ROOT_W-1:0]          root_fin;

    assign root_fin = sq_root_reg[ROOT_W][ROOT_W-1:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num_next[i] = (NUM_W'(sq_mag_reg[ROOT_W][i]) << FRAC) + NUM_W'(root_fin >> 1);
        end
    end

    always_comb begin
        logic [NUM_W-1:0] dsh;
        logic             take;
        for (int j = 0; j < Q_W; j++) begin
            dsh = NUM_W'(dv_den_reg[j]) << (Q_W - 1 - j);
            for (int i = 0; i < 3; i++) begin
                take = (dv_rem_reg[j][i] >= dsh);
                dv_rem_next[j][i] = take ? (dv_rem_reg[j][i] - dsh) : dv_rem_reg[j][i];
                dv_q_next[j][i]   = {dv_q_reg[j][i][Q_W-2:0], take};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= Q_W; j++) begin
                dv_valid_reg[j] <= 1'b0;
            end
        end else if (en) begin
            dv_valid_reg[0] <= sq_valid_reg[ROOT_W];
            for (int j = 0; j < Q_W; j++) begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_rem_reg[0]  <= num_next;
            dv_q_reg[0]    <= '0;
            dv_den_reg[0]  <= root_fin;
            dv_neg_reg[0]  <= sq_neg_reg[ROOT_W];
            dv_zero_reg[0] <= (root_fin == '0);
            dv_side_reg[0] <= sq_side_reg[ROOT_W];
            for (int j = 0; j < Q_W; j++) begin
                dv_rem_reg[j+1]  <= dv_rem_next[j];
                dv_q_reg[j+1]    <= dv_q_next[j];
                dv_den_reg[j+1]  <= dv_den_reg[j];
                dv_neg_reg[j+1]  <= dv_neg_reg[j];
                dv_zero_reg[j+1] <= dv_zero_reg[j];
                dv_side_reg[j+1] <= dv_side_reg[j];
            end
        end
    end

    // ---------------- output stage: sign restore, zero vector forced to zeros
    logic                       o_valid_reg;
    rbo_pkg::vec3_t             o_vec_reg, o_vec_next;
    logic                       o_zero_reg;
    rbo_pkg::side_t             o_side_reg;

    always_comb begin
        logic [CW-1:0] qext;
        for (int i = 0; i < 3; i++) begin
            qext = {{(CW-Q_W){1'b0}}, dv_q_reg[Q_W][i]};
            if (dv_zero_reg[Q_W]) begin
                o_vec_next[i] = '0;
            end else if (dv_neg_reg[Q_W][i]) begin
                o_vec_next[i] = ~qext + 1'b1;
            end else begin
                o_vec_next[i] = qext;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (en) begin
            o_valid_reg <= dv_valid_reg[Q_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_vec_reg  <= o_vec_next;
            o_zero_reg <= dv_zero_reg[Q_W];
            o_side_reg <= dv_side_reg[Q_W];
        end
    end

    assign out_valid = o_valid_reg;
    assign out_vec   = o_vec_reg;
    assign out_zero  = o_zero_reg;
    assign out_side  = o_side_reg;

endmodule

[rtl/core/rbo_cross.sv]
`timescale 1ns / 1ps
// Two-stage exact cross product of two unit vectors (products, then differences).
// Uses rbo_pkg; feeds rbo_norm.
module rbo_cross (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  rbo_pkg::vec3_t in_a,
    input  rbo_pkg::vec3_t in_b,
    input  rbo_pkg::side_t in_side,
    output logic           out_valid,
    output rbo_pkg::wvec_t out_vec,
    output rbo_pkg::side_t out_side
);

    localparam int VEC_W = rbo_pkg::VEC_W;
    localparam int CW    = rbo_pkg::COMPONENT_WIDTH;

    // stage 1: the six products
    logic                    p_valid_reg;
    logic signed [VEC_W-1:0] p_reg  [6];
    logic signed [VEC_W-1:0] p_next [6];
    rbo_pkg::side_t          p_side_reg;

    always_comb begin
        logic signed [CW-1:0] a0, a1, a2, b0, b1, b2;
        a0 = in_a[0];
        a1 = in_a[1];
        a2 = in_a[2];
        b0 = in_b[0];
        b1 = in_b[1];
        b2 = in_b[2];
        p_next[0] = a1 * b2;
        p_next[1] = a2 * b1;
        p_next[2] = a2 * b0;
        p_next[3] = a0 * b2;
        p_next[4] = a0 * b1;
        p_next[5] = a1 * b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (en) begin
            p_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg      <= p_next;
            p_side_reg <= in_side;
        end
    end

    // stage 2: differences
    logic           r_valid_reg;
    rbo_pkg::wvec_t r_vec_reg, r_vec_next;
    rbo_pkg::side_t r_side_reg;

    always_comb begin
        r_vec_next[0] = p_reg[0] - p_reg[1];
        r_vec_next[1] = p_reg[2] - p_reg[3];
        r_vec_next[2] = p_reg[4] - p_reg[5];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
        end else if (en) begin
            r_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_vec_reg  <= r_vec_next;
            r_side_reg <= p_side_reg;
        end
    end

    assign out_valid = r_valid_reg;
    assign out_vec   = r_vec_reg;
    assign out_side  = r_side_reg;

endmodule

[rtl/core/rotation_basis_orthonormalizer_top.sv]
`timescale 1ns / 1ps
// Top level of the rotation basis orthonormalizer: normalizer and cross-product
// pipeline chain plus a two-entry output buffer. Uses rbo_pkg, rbo_norm, rbo_cross.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  s_      | in        | s_valid / s_ready  | s_x_axis_{x,y,z}, s_y_axis_{x,y,z}
//  m_      | out       | m_valid / m_ready  | m_out_{x,y,z}_{x,y,z}, m_degenerate
//
// One transaction per cycle in and out while the output buffer has room and the receiver
// takes results. A result passes four normalizers of 51 stages each in series (X and Y
// run side by side; 32 square-root and 16 divide stages dominate), three 2-stage cross
// products, and the output buffer register before it can be taken.
// Reset (aresetn low, synchronous) clears all valid bits and empties the buffer.
// When the two-entry buffer is full the whole pipeline holds; nothing is lost.
module rotation_basis_orthonormalizer_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rbo_pkg::comp_t        s_x_axis_x,
    input  rbo_pkg::comp_t        s_x_axis_y,
    input  rbo_pkg::comp_t        s_x_axis_z,
    input  rbo_pkg::comp_t        s_y_axis_x,
    input  rbo_pkg::comp_t        s_y_axis_y,
    input  rbo_pkg::comp_t        s_y_axis_z,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rbo_pkg::comp_t        m_out_x_x,
    output rbo_pkg::comp_t        m_out_x_y,
    output rbo_pkg::comp_t        m_out_x_z,
    output rbo_pkg::comp_t        m_out_y_x,
    output rbo_pkg::comp_t        m_out_y_y,
    output rbo_pkg::comp_t        m_out_y_z,
    output rbo_pkg::comp_t        m_out_z_x,
    output rbo_pkg::comp_t        m_out_z_y,
    output rbo_pkg::comp_t        m_out_z_z,
    output logic                  m_degenerate
);

    localparam int VEC_W = rbo_pkg::VEC_W;
    localparam int CW    = rbo_pkg::COMPONENT_WIDTH;

    logic en;
    logic [1:0] cnt_reg, cnt_next;

    // pipeline advances whenever the output buffer has room
    assign en      = (cnt_reg != 2'd2);
    assign s_ready = en;

    // sign-extend inputs to the normalizer width
    rbo_pkg::wvec_t xin, yin;
    assign xin[0] = {{(VEC_W-CW){s_x_axis_x[CW-1]}}, s_x_axis_x};
    assign xin[1] = {{(VEC_W-CW){s_x_axis_y[CW-1]}}, s_x_axis_y};
    assign xin[2] = {{(VEC_W-CW){s_x_axis_z[CW-1]}}, s_x_axis_z};
    assign yin[0] = {{(VEC_W-CW){s_y_axis_x[CW-1]}}, s_y_axis_x};
    assign yin[1] = {{(VEC_W-CW){s_y_axis_y[CW-1]}}, s_y_axis_y};
    assign yin[2] = {{(VEC_W-CW){s_y_axis_z[CW-1]}}, s_y_axis_z};

    // ---------------- first pass: X and Y in parallel
    logic           nx_valid, ny_valid, nx_zero, ny_zero;
    rbo_pkg::vec3_t nx_vec, ny_vec;
    rbo_pkg::side_t nx_side, ny_side;

    rbo_norm u_norm_x (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_valid), .in_vec(xin), .in_side('0),
        .out_valid(nx_valid), .out_vec(nx_vec), .out_zero(nx_zero), .out_side(nx_side)
    );

    rbo_norm u_norm_y (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_valid), .in_vec(yin), .in_side('0),
        .out_valid(ny_valid), .out_vec(ny_vec), .out_zero(ny_zero), .out_side(ny_side)
    );

    // ---------------- Z = norm(X x Y), carry Y
    rbo_pkg::side_t c1_side_in;
    logic           c1_valid;
    rbo_pkg::wvec_t c1_vec;
    rbo_pkg::side_t c1_side;

    assign c1_side_in.va  = ny_vec;
    assign c1_side_in.vb  = '0;
    assign c1_side_in.deg = nx_zero | ny_zero | nx_side.deg | ny_side.deg;

    rbo_cross u_cross_z (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(nx_valid & ny_valid), .in_a(nx_vec), .in_b(ny_vec), .in_side(c1_side_in),
        .out_valid(c1_valid), .out_vec(c1_vec), .out_side(c1_side)
    );

    logic           nz_valid, nz_zero;
    rbo_pkg::vec3_t nz_vec;
    rbo_pkg::side_t nz_side;

    rbo_norm u_norm_z (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(c1_valid), .in_vec(c1_vec), .in_side(c1_side),
        .out_valid(nz_valid), .out_vec(nz_vec), .out_zero(nz_zero), .out_side(nz_side)
    );

    // ---------------- X' = norm(Y x Z), carry Z
    rbo_pkg::side_t c2_side_in;
    logic           c2_valid;
    rbo_pkg::wvec_t c2_vec;
    rbo_pkg::side_t c2_side;

    assign c2_side_in.va  = nz_vec;
    assign c2_side_in.vb  = '0;
    assign c2_side_in.deg = nz_side.deg | nz_zero;

    rbo_cross u_cross_x (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(nz_valid), .in_a(nz_side.va), .in_b(nz_vec), .in_side(c2_side_in),
        .out_valid(c2_valid), .out_vec(c2_vec), .out_side(c2_side)
    );

    logic           nx2_valid, nx2_zero;
    rbo_pkg::vec3_t nx2_vec;
    rbo_pkg::side_t nx2_side;

    rbo_norm u_norm_x2 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(c2_valid), .in_vec(c2_vec), .in_side(c2_side),
        .out_valid(nx2_valid), .out_vec(nx2_vec), .out_zero(nx2_zero), .out_side(nx2_side)
    );

    // ---------------- Y' = norm(Z x X'), carry Z and X'
    rbo_pkg::side_t c3_side_in;
    logic           c3_valid;
    rbo_pkg::wvec_t c3_vec;
    rbo_pkg::side_t c3_side;

    assign c3_side_in.va  = nx2_side.va;
    assign c3_side_in.vb  = nx2_vec;
    assign c3_side_in.deg = nx2_side.deg | nx2_zero;

    rbo_cross u_cross_y (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(nx2_valid), .in_a(nx2_side.va), .in_b(nx2_vec), .in_side(c3_side_in),
        .out_valid(c3_valid), .out_vec(c3_vec), .out_side(c3_side)
    );

    logic           ny2_valid, ny2_zero;
    rbo_pkg::vec3_t ny2_vec;
    rbo_pkg::side_t ny2_side;

    rbo_norm u_norm_y2 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(c3_valid), .in_vec(c3_vec), .in_side(c3_side),
        .out_valid(ny2_valid), .out_vec(ny2_vec), .out_zero(ny2_zero), .out_side(ny2_side)
    );

    // ---------------- two-entry output buffer
    rbo_pkg::res_t fin;
    rbo_pkg::res_t head_reg, head_next, tail_reg, tail_next;
    logic push, pop;

    assign fin.x   = ny2_side.vb;
    assign fin.y   = ny2_vec;
    assign fin.z   = ny2_side.va;
    assign fin.deg = ny2_side.deg | ny2_zero;

    assign push = en & ny2_valid;
    assign pop  = m_valid & m_ready;

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        if (push && !pop) begin
            if (cnt_reg == 2'd0) begin
                head_next = fin;
            end else begin
                tail_next = fin;
            end
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            head_next = tail_reg;
            cnt_next  = cnt_reg - 2'd1;
        end else if (push && pop) begin
            head_next = fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign m_valid      = (cnt_reg != 2'd0);
    assign m_out_x_x    = head_reg.x[0];
    assign m_out_x_y    = head_reg.x[1];
    assign m_out_x_z    = head_reg.x[2];
    assign m_out_y_x    = head_reg.y[0];
    assign m_out_y_y    = head_reg.y[1];
    assign m_out_y_z    = head_reg.y[2];
    assign m_out_z_x    = head_reg.z[0];
    assign m_out_z_y    = head_reg.z[1];
    assign m_out_z_z    = head_reg.z[2];
    assign m_degenerate = head_reg.deg;

    // ---------------- checks
    // buffer occupancy never exceeds two
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("output buffer overflow");

    // a full buffer stops the pipeline, so nothing is pushed
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !push)
        else $error("push into full output buffer");

    // a non-degenerate result has a non-zero Z axis
    a_z_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_degenerate) |->
        ((m_out_z_x != '0) || (m_out_z_y != '0) || (m_out_z_z != '0)))
        else $error("zero Z axis without degenerate flag");

    // a non-degenerate result has a non-zero X axis
    a_x_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_degenerate) |->
        ((m_out_x_x != '0) || (m_out_x_y != '0) || (m_out_x_z != '0)))
        else $error("zero X axis without degenerate flag");

endmodule

[test/rotation_basis_orthonormalizer_top_test.sv]
`timescale 1ns / 1ps
// Testbench for rotation_basis_orthonormalizer_top: directed and random basis sets
// checked against an in-bench fixed-point orthonormalization model. Uses rbo_pkg.
module rotation_basis_orthonormalizer_top_test;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 250;

    typedef logic signed [63:0] s64_t;

    typedef struct packed {
        rbo_pkg::comp_t [2:0] x;
        rbo_pkg::comp_t [2:0] y;
        rbo_pkg::comp_t [2:0] z;
        logic                 deg;
    } basis_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    rbo_pkg::comp_t  s_x_axis_x = '0, s_x_axis_y = '0, s_x_axis_z = '0;
    rbo_pkg::comp_t  s_y_axis_x = '0, s_y_axis_y = '0, s_y_axis_z = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    rbo_pkg::comp_t  m_out_x_x, m_out_x_y, m_out_x_z;
    rbo_pkg::comp_t  m_out_y_x, m_out_y_y, m_out_y_z;
    rbo_pkg::comp_t  m_out_z_x, m_out_z_y, m_out_z_z;
    logic            m_degenerate;

    basis_t expected_bases[$];
    int     error_count = 0;
    int     idle_cycles = 0;
    bit     stim_done = 1'b0;

    rotation_basis_orthonormalizer_top u_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Integer square root, floor
    function automatic logic [63:0] int_sqrt(input logic [63:0] s);
        logic [63:0] root, bit_v;
        root = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > s) bit_v >>= 2;
        while (bit_v != 0) begin
            if (s >= root + bit_v) begin
                s -= root + bit_v;
                root = (root >> 1) + bit_v;
            end else begin
                root >>= 1;
            end
            bit_v >>= 2;
        end
        return root;
    endfunction

    // Normalize to unit length, round half away from zero; returns 1 on zero length
    function automatic bit unit_vector(input s64_t v[3], output s64_t r[3]);
        logic [63:0] mag[3];
        logic [63:0] m, s, n, q;
        m = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (v[i] < 0) ? -v[i] : v[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
            for (int i = 0; i < 3; i++) r[i] = 0;
            return 1'b1;
        end
        while (m >= (64'd1 << 31)) begin
            m >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
        n = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << rbo_pkg::FRAC_BITS) + (n >> 1)) / n;
            r[i] = (v[i] < 0) ? -s64_t'(q) : s64_t'(q);
        end
        return 1'b0;
    endfunction

    function automatic void cross_prod(input s64_t a[3], input s64_t b[3],
                                       output s64_t r[3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic basis_t orthonormal_basis(input rbo_pkg::comp_t [2:0] xin,
                                                 input rbo_pkg::comp_t [2:0] yin);
        s64_t xa[3], ya[3], za[3], t[3];
        basis_t b;
        bit deg;
        for (int i = 0; i < 3; i++) t[i] = s64_t'($signed(xin[i]));
        deg = unit_vector(t, xa);
        for (int i = 0; i < 3; i++) t[i] = s64_t'($signed(yin[i]));
        deg |= unit_vector(t, ya);
        cross_prod(xa, ya, t);
        deg |= unit_vector(t, za);
        cross_prod(ya, za, t);
        deg |= unit_vector(t, xa);
        cross_prod(za, xa, t);
        deg |= unit_vector(t, ya);
        for (int i = 0; i < 3; i++) begin
            b.x[i] = rbo_pkg::comp_t'(xa[i]);
            b.y[i] = rbo_pkg::comp_t'(ya[i]);
            b.z[i] = rbo_pkg::comp_t'(za[i]);
        end
        b.deg = deg;
        return b;
    endfunction

    // Send one basis set after a random gap; index 0 is the x component.
    // s_valid stays high across back-to-back transactions.
    task automatic send_basis(input rbo_pkg::comp_t [2:0] xin,
                              input rbo_pkg::comp_t [2:0] yin);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_x_axis_x <= xin[0];
        s_x_axis_y <= xin[1];
        s_x_axis_z <= xin[2];
        s_y_axis_x <= yin[0];
        s_y_axis_y <= yin[1];
        s_y_axis_z <= yin[2];
        do @(posedge aclk); while (!s_ready);
        expected_bases.push_back(orthonormal_basis(xin, yin));
    endtask

    function automatic rbo_pkg::comp_t rand_comp();
        case ($urandom_range(0, 5))
            0: return rbo_pkg::comp_t'($urandom_range(0, 4) * 16'h4000);
            1: return rbo_pkg::comp_t'($urandom_range(0, 15)) - 16'd8;
            default: return rbo_pkg::comp_t'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        rbo_pkg::comp_t [2:0] a, b;
        rbo_pkg::comp_t mn, mx, one;
        mn = 16'h8000; mx = 16'h7fff; one = 16'h4000;
        send_basis({16'd0, 16'd0, one}, {16'd0, one, 16'd0});       // identity
        send_basis({16'd0, 16'd0, 16'd0}, {16'd0, one, 16'd0});     // zero X
        send_basis({16'd0, 16'd0, one}, {16'd0, 16'd0, 16'd0});     // zero Y
        send_basis({16'd0, 16'd0, 16'd0}, {16'd0, 16'd0, 16'd0});
        send_basis({16'd0, 16'd0, one}, {16'd0, 16'd0, mx});        // parallel
        send_basis({16'd0, 16'd0, mn}, {16'd0, 16'd0, one});        // antiparallel
        send_basis({mn, mn, mn}, {mx, mx, mn});
        send_basis({mx, mx, mx}, {mn, mx, mx});
        send_basis({mn, 16'd0, 16'd0}, {16'd0, mn, 16'd0});
        send_basis({16'd1, 16'd0, 16'd0}, {16'd0, 16'hffff, 16'd0});
        send_basis({16'd1, 16'd1, 16'd1}, {16'd1, 16'hffff, 16'd0});
        send_basis({16'h5555, 16'haaaa, 16'd3}, {16'haaaa, 16'h5555, 16'hfffd});
        for (int i = 0; i < 8; i++) begin
            a = {rand_comp(), rand_comp(), rand_comp()};
            b = {rand_comp(), rand_comp(), rand_comp()};
            send_basis(a, b);
        end
    endtask

    task automatic test_random(input int count);
        rbo_pkg::comp_t [2:0] a, b;
        for (int i = 0; i < count; i++) begin
            a = {rand_comp(), rand_comp(), rand_comp()};
            case ($urandom_range(0, 9))
                0: b = a;                                     // parallel
                1: b = {16'd0, 16'd0, 16'd0};
                2: b = {a[1], -a[0], a[2]};
                default: b = {rand_comp(), rand_comp(), rand_comp()};
            endcase
            send_basis(a, b);
        end
    endtask

    // Hold off new input until the pipeline has fully drained
    task automatic test_drain_pause();
        s_valid <= 1'b0;
        while (expected_bases.size() != 0) @(posedge aclk);
        test_random(50);
    endtask

    // Result side: random stalls, compare each transaction
    always @(posedge aclk) begin
        basis_t exp_b;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_bases.size() == 0) begin
                    $error("result with no expectation pending");
                    error_count++;
                end else begin
                    exp_b = expected_bases.pop_front();
                    for (int i = 0; i < 3; i++) begin
                        rbo_pkg::comp_t ax, ay, az;
                        string          sfx;
                        sfx = i == 0 ? "x" : i == 1 ? "y" : "z";
                        ax = i == 0 ? m_out_x_x : i == 1 ? m_out_x_y : m_out_x_z;
                        ay = i == 0 ? m_out_y_x : i == 1 ? m_out_y_y : m_out_y_z;
                        az = i == 0 ? m_out_z_x : i == 1 ? m_out_z_y : m_out_z_z;
                        if (ax !== exp_b.x[i]) begin
                            $error("out_x_%s expected %h actual %h", sfx, exp_b.x[i], ax);
                            error_count++;
                        end
                        if (ay !== exp_b.y[i]) begin
                            $error("out_y_%s expected %h actual %h", sfx, exp_b.y[i], ay);
                            error_count++;
                        end
                        if (az !== exp_b.z[i]) begin
                            $error("out_z_%s expected %h actual %h", sfx, exp_b.z[i], az);
                            error_count++;
                        end
                    end
                    if (m_degenerate !== exp_b.deg) begin
                        $error("degenerate expected %b actual %b", exp_b.deg, m_degenerate);
                        error_count++;
                    end
                end
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Receiver stall pattern: m_ready drops for a random wait before each transaction
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(600);
        test_drain_pause();
        test_random(550);
        s_valid <= 1'b0;
        while (expected_bases.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_bases.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/rbo_pkg.sv
rtl/core/rbo_norm.sv
rtl/core/rbo_cross.sv
rtl/core/rotation_basis_orthonormalizer_top.sv
test/rotation_basis_orthonormalizer_top_test.sv
